@@ hw/rtl/robin_hood_hash_table_defines.svh @@
// Assertion macros shared by the checker.
`ifndef ROBIN_HOOD_HASH_TABLE_DEFINES_SVH
`define ROBIN_HOOD_HASH_TABLE_DEFINES_SVH
`define RH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ hw/rtl/rhht_pkg.sv @@
package rhht_pkg;
  localparam int unsigned TableSlots = 1024;
  localparam int unsigned KeyBits = 32;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned LoadNum = 9;
  localparam int unsigned LoadDen = 10;
  localparam int unsigned CountW = 11;

  localparam logic [2:0] ModeLookup = 3'd0;
  localparam logic [2:0] ModeAdd = 3'd1;
  localparam logic [2:0] ModeSet = 3'd2;
  localparam logic [2:0] ModeRemove = 3'd3;
  localparam logic [2:0] ModeClear = 3'd4;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StPresent = 2'd1;
  localparam logic [1:0] StFull = 2'd2;
  localparam logic [1:0] StMissing = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] key;
    logic [31:0] key_hash;
    logic [31:0] value_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_out;
    logic [10:0] stored_count;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic restart;
    logic rd;
    logic cmp;
    logic ins_step;
    logic ins_write;
    logic upd_write;
    logic rm_rd;
    logic rm_step;
    logic rm_free;
    logic clr_step;
    logic clr_start;
    logic cnt_clear;
  } cmd_t;

  typedef struct packed {
    logic used;
    logic stop;
    logic match;
    logic poorer;
    logic nx_stop;
    logic full;
    logic empty;
    logic clr_done;
  } sts_t;
endpackage

@@ hw/rtl/rhht_if.sv @@
interface rhht_req_if;
  logic valid;
  logic ready;
  rhht_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rhht_rsp_if;
  logic valid;
  logic ready;
  rhht_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/robin_hood_hash_table.sv @@
// Robin Hood hash table with backward-shift deletion.
// The request channel carries one word per operation: mode, key, key_hash
// and value_in. The response channel returns one word per request with
// status, value_out and stored_count, the entry count after the operation.
// The home slot is the low bits of key_hash; the hash is computed outside.
// One request is handled at a time. Each slot probed passes through the
// states SFLoad, SFRd and SFCmp, as the slot memory has a registered read
// port; on an empty table the read is skipped. Insert walks each slot
// through SIRd and SICmp, and remove shifts each entry back through SRRd
// and SRCmp. Clear walks every slot, one per cycle.
// Reset clears the occupancy marks and the count at once; key and value
// storage is not reset. The response word is held in place while the
// receiver stalls, and no new request is taken until it is delivered.
module robin_hood_hash_table #(
  parameter int unsigned TableSlots = rhht_pkg::TableSlots,
  parameter int unsigned KeyBits = rhht_pkg::KeyBits,
  parameter int unsigned ValueBits = rhht_pkg::ValueBits
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  rhht_req_if.sink   req,
  rhht_rsp_if.source rsp
);
  rhht_pkg::cmd_t cmd;
  rhht_pkg::sts_t sts;
  logic [31:0] found_value;
  logic [10:0] count;
  logic take_value;
  logic [1:0] status;

  rhht_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req.valid), .in_ready_o(req.ready), .mode_i(req.data.mode),
    .out_valid_o(rsp.valid), .out_ready_i(rsp.ready),
    .status_o(status), .take_value_o(take_value),
    .cmd_o(cmd), .sts_i(sts)
  );

  rhht_datapath #(.TableSlots(TableSlots), .KeyBits(KeyBits), .ValueBits(ValueBits)) u_dp (
    .clk_i, .rst_ni, .req_i(req.data), .cmd_i(cmd), .sts_o(sts),
    .found_value_o(found_value), .count_o(count)
  );

  assign rsp.data.status = status;
  assign rsp.data.value_out = take_value ? found_value : 32'd0;
  assign rsp.data.stored_count = count;
endmodule

@@ hw/rtl/rhht_datapath.sv @@
module rhht_datapath #(
  parameter int unsigned TableSlots = rhht_pkg::TableSlots,
  parameter int unsigned KeyBits = rhht_pkg::KeyBits,
  parameter int unsigned ValueBits = rhht_pkg::ValueBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rhht_pkg::req_t     req_i,
  input  rhht_pkg::cmd_t     cmd_i,
  output rhht_pkg::sts_t     sts_o,
  output logic [31:0]        found_value_o,
  output logic [10:0]        count_o
);
  localparam int unsigned IdxW = $clog2(TableSlots);
  localparam int unsigned EntW = 32 + KeyBits + ValueBits;

  logic [EntW-1:0] mem_q [TableSlots];
  logic [TableSlots-1:0] used_q;
  logic [EntW-1:0] rd_q;
  logic rd_used_q;
  logic [IdxW-1:0] idx_q, rd_addr;
  logic [IdxW-1:0] dist_q;
  logic [31:0] hash_q;
  logic [KeyBits-1:0] key_q;
  logic [ValueBits-1:0] val_q;
  logic [IdxW-1:0] clr_q;
  logic [10:0] count_q;
  logic [IdxW-1:0] od;
  logic [31:0] rd_hash;
  logic [KeyBits-1:0] rd_key;
  logic [ValueBits-1:0] rd_val;

  assign rd_hash = rd_q[EntW-1 -: 32];
  assign rd_key = rd_q[ValueBits +: KeyBits];
  assign rd_val = rd_q[ValueBits-1:0];
  assign od = idx_q - rd_hash[IdxW-1:0];
  assign rd_addr = (cmd_i.rm_rd) ? idx_q + 1'b1 : idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd || cmd_i.rm_rd) begin
      rd_q <= mem_q[rd_addr];
    end
    if (cmd_i.ins_write || cmd_i.ins_step) begin
      mem_q[idx_q] <= {hash_q, key_q, val_q};
    end else if (cmd_i.upd_write) begin
      mem_q[idx_q] <= {rd_hash, rd_key, val_q};
    end else if (cmd_i.rm_step) begin
      mem_q[idx_q] <= rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      rd_used_q <= 1'b0;
      count_q <= '0;
      clr_q <= '0;
    end else begin
      if (cmd_i.rd || cmd_i.rm_rd) begin
        rd_used_q <= used_q[rd_addr];
      end
      if (cmd_i.ins_write) begin
        used_q[idx_q] <= 1'b1;
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.rm_free) begin
        used_q[idx_q] <= 1'b0;
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.clr_start) begin
        clr_q <= '0;
      end else if (cmd_i.clr_step) begin
        used_q[clr_q] <= 1'b0;
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.cnt_clear) begin
        count_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q <= req_i.key_hash[IdxW-1:0];
      dist_q <= '0;
      hash_q <= req_i.key_hash;
      key_q <= req_i.key[KeyBits-1:0];
      val_q <= req_i.value_in[ValueBits-1:0];
    end else if (cmd_i.restart) begin
      idx_q <= hash_q[IdxW-1:0];
      dist_q <= '0;
    end else if (cmd_i.ins_step) begin
      hash_q <= rd_hash;
      key_q <= rd_key;
      val_q <= rd_val;
      dist_q <= od + 1'b1;
      idx_q <= idx_q + 1'b1;
    end else if (cmd_i.cmp) begin
      dist_q <= dist_q + 1'b1;
      idx_q <= idx_q + 1'b1;
    end else if (cmd_i.rm_step) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  assign sts_o.used = rd_used_q;
  assign sts_o.match = rd_used_q && (rd_hash == hash_q) && (rd_key == key_q);
  assign sts_o.poorer = dist_q > od;
  assign sts_o.stop = !rd_used_q || (dist_q > od);
  assign sts_o.nx_stop = !rd_used_q || (rd_hash[IdxW-1:0] == idx_q + 1'b1);
  assign sts_o.full = (32'(count_q) * rhht_pkg::LoadDen) >= (TableSlots * rhht_pkg::LoadNum);
  assign sts_o.empty = (count_q == '0);
  assign sts_o.clr_done = (clr_q == IdxW'(TableSlots - 1));
  assign found_value_o = 32'(rd_val);
  assign count_o = count_q;
endmodule

@@ hw/rtl/rhht_ctrl.sv @@
module rhht_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [2:0]     mode_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     status_o,
  output logic           take_value_o,
  output rhht_pkg::cmd_t cmd_o,
  input  rhht_pkg::sts_t sts_i
);
  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SFRd = 4'd1;
  localparam logic [3:0] SFCmp = 4'd2;
  localparam logic [3:0] SIRd = 4'd3;
  localparam logic [3:0] SICmp = 4'd4;
  localparam logic [3:0] SRRd = 4'd5;
  localparam logic [3:0] SRCmp = 4'd6;
  localparam logic [3:0] SClr = 4'd7;
  localparam logic [3:0] SOut = 4'd8;
  localparam logic [3:0] SFLoad = 4'd9;

  logic [3:0] state_q, state_d;
  logic [2:0] mode_q, mode_d;
  logic [1:0] st_q, st_d;
  logic tv_q, tv_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      mode_q <= '0;
      st_q <= rhht_pkg::StOk;
      tv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q <= mode_d;
      st_q <= st_d;
      tv_q <= tv_d;
    end
  end

  always_comb begin
    state_d = state_q;
    mode_d = mode_q;
    st_d = st_q;
    tv_d = tv_q;
    cmd_o = '0;
    in_ready_o = (state_q == SIdle);
    out_valid_o = (state_q == SOut);
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          mode_d = mode_i;
          st_d = rhht_pkg::StOk;
          tv_d = 1'b0;
          case (mode_i)
            rhht_pkg::ModeLookup, rhht_pkg::ModeAdd, rhht_pkg::ModeSet,
            rhht_pkg::ModeRemove: state_d = SFLoad;
            rhht_pkg::ModeClear: begin
              cmd_o.clr_start = 1'b1;
              state_d = SClr;
            end
            default: state_d = SOut;
          endcase
        end
      end
      SFLoad: begin
        if (sts_i.empty) begin
          st_d = rhht_pkg::StMissing;
          state_d = SFCmp;
        end else begin
          cmd_o.rd = 1'b1;
          state_d = SFRd;
        end
      end
      SFRd: state_d = SFCmp;
      SFCmp: begin
        if (st_q != rhht_pkg::StMissing && !sts_i.stop && sts_i.match) begin
          case (mode_q)
            rhht_pkg::ModeLookup: begin
              tv_d = 1'b1;
              state_d = SOut;
            end
            rhht_pkg::ModeAdd: begin
              st_d = rhht_pkg::StPresent;
              state_d = SOut;
            end
            rhht_pkg::ModeSet: begin
              cmd_o.upd_write = 1'b1;
              state_d = SOut;
            end
            default: begin
              cmd_o.rm_rd = 1'b1;
              state_d = SRRd;
            end
          endcase
        end else if (st_q == rhht_pkg::StMissing || sts_i.stop) begin
          if (mode_q == rhht_pkg::ModeLookup || mode_q == rhht_pkg::ModeRemove) begin
            st_d = rhht_pkg::StMissing;
            state_d = SOut;
          end else if (sts_i.full) begin
            st_d = rhht_pkg::StFull;
            state_d = SOut;
          end else begin
            st_d = rhht_pkg::StOk;
            cmd_o.restart = 1'b1;
            state_d = SIRd;
          end
        end else begin
          cmd_o.cmp = 1'b1;
          state_d = SFLoad;
        end
      end
      SIRd: begin
        cmd_o.rd = 1'b1;
        state_d = SICmp;
      end
      SICmp: begin
        if (!sts_i.used) begin
          cmd_o.ins_write = 1'b1;
          state_d = SOut;
        end else if (sts_i.poorer) begin
          cmd_o.ins_step = 1'b1;
          state_d = SIRd;
        end else begin
          cmd_o.cmp = 1'b1;
          state_d = SIRd;
        end
      end
      SRRd: begin
        cmd_o.rm_rd = 1'b1;
        state_d = SRCmp;
      end
      SRCmp: begin
        if (sts_i.nx_stop) begin
          cmd_o.rm_free = 1'b1;
          state_d = SOut;
        end else begin
          cmd_o.rm_step = 1'b1;
          state_d = SRRd;
        end
      end
      SClr: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          cmd_o.cnt_clear = 1'b1;
          state_d = SOut;
        end
      end
      SOut: begin
        if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  assign status_o = st_q;
  assign take_value_o = tv_q;
endmodule

@@ hw/rtl/rhht_checker.sv @@
`include "robin_hood_hash_table_defines.svh"
module rhht_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rhht_pkg::rsp_t out_data
);
  `RH_ASSERT_IMPL(a_one_at_a_time, clk_i, rst_ni, out_valid, !in_ready)
  `RH_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_data))
  `RH_ASSERT_IMPL(a_value_ok, clk_i, rst_ni, out_valid && out_data.status != rhht_pkg::StOk, out_data.value_out == 32'd0)
  `RH_ASSERT_NEXT(a_idle_after_resp, clk_i, rst_ni, out_valid && out_ready, !out_valid && in_ready)
endmodule

bind robin_hood_hash_table rhht_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(req.valid), .in_ready(req.ready),
  .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
);

@@ bench/robin_hood_hash_table_tb.sv @@
`timescale 1ns / 1ps

module robin_hood_hash_table_tb;
  localparam int unsigned Slots = rhht_pkg::TableSlots;
  localparam int unsigned SlotMask = Slots - 1;
  localparam int unsigned LimitCycles = 2000000;

  logic clk_i;
  logic rst_ni;

  rhht_req_if req_if ();
  rhht_rsp_if rsp_if ();

  robin_hood_hash_table dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_if.sink),
    .rsp   (rsp_if.source)
  );

  bit          tbl_used[Slots];
  logic [31:0] tbl_hash[Slots];
  logic [31:0] tbl_key[Slots];
  logic [31:0] tbl_val[Slots];
  int unsigned tbl_count;

  rhht_pkg::req_t pending_words[$];
  rhht_pkg::rsp_t expected_words[$];
  logic [31:0] live_keys[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  bit stimulus_done;
  bit idle_off;
  bit long_hold;

  function automatic int unsigned home_dist(int unsigned idx);
    return (idx - (tbl_hash[idx] & SlotMask)) & SlotMask;
  endfunction

  function automatic bit locate(logic [31:0] h, logic [31:0] k, output int unsigned at);
    int unsigned idx;
    int unsigned probe_dist;
    idx = h & SlotMask;
    probe_dist = 0;
    at = 0;
    if (tbl_count == 0) return 0;
    for (int n = 0; n < Slots; n++) begin
      if (!tbl_used[idx]) return 0;
      if (probe_dist > home_dist(idx)) return 0;
      if (tbl_hash[idx] == h && tbl_key[idx] == k) begin
        at = idx;
        return 1;
      end
      idx = (idx + 1) & SlotMask;
      probe_dist++;
    end
    return 0;
  endfunction

  function automatic void place_new(logic [31:0] h, logic [31:0] k, logic [31:0] v);
    int unsigned idx;
    int unsigned probe_dist;
    int unsigned od;
    logic [31:0] th, tk, tv;
    idx = h & SlotMask;
    probe_dist = 0;
    for (int n = 0; n < Slots; n++) begin
      if (!tbl_used[idx]) begin
        tbl_used[idx] = 1;
        tbl_hash[idx] = h;
        tbl_key[idx] = k;
        tbl_val[idx] = v;
        tbl_count++;
        return;
      end
      od = home_dist(idx);
      if (probe_dist > od) begin
        th = tbl_hash[idx];
        tk = tbl_key[idx];
        tv = tbl_val[idx];
        tbl_hash[idx] = h;
        tbl_key[idx] = k;
        tbl_val[idx] = v;
        h = th;
        k = tk;
        v = tv;
        probe_dist = od;
      end
      idx = (idx + 1) & SlotMask;
      probe_dist++;
    end
  endfunction

  function automatic void shift_out(int unsigned idx);
    int unsigned nx;
    for (int n = 0; n < Slots; n++) begin
      nx = (idx + 1) & SlotMask;
      if (!tbl_used[nx] || home_dist(nx) == 0) break;
      tbl_hash[idx] = tbl_hash[nx];
      tbl_key[idx] = tbl_key[nx];
      tbl_val[idx] = tbl_val[nx];
      idx = nx;
    end
    tbl_used[idx] = 0;
    tbl_count--;
  endfunction

  function automatic rhht_pkg::rsp_t table_response(rhht_pkg::req_t w);
    rhht_pkg::rsp_t r;
    int unsigned at;
    bit found;
    bit full;
    r = '0;
    r.status = rhht_pkg::StOk;
    found = locate(w.key_hash, w.key, at);
    full = (tbl_count * rhht_pkg::LoadDen) >= (Slots * rhht_pkg::LoadNum);
    case (w.mode)
      rhht_pkg::ModeLookup: begin
        if (found) r.value_out = tbl_val[at];
        else r.status = rhht_pkg::StMissing;
      end
      rhht_pkg::ModeAdd: begin
        if (found) r.status = rhht_pkg::StPresent;
        else if (full) r.status = rhht_pkg::StFull;
        else place_new(w.key_hash, w.key, w.value_in);
      end
      rhht_pkg::ModeSet: begin
        if (found) tbl_val[at] = w.value_in;
        else if (full) r.status = rhht_pkg::StFull;
        else place_new(w.key_hash, w.key, w.value_in);
      end
      rhht_pkg::ModeRemove: begin
        if (found) shift_out(at);
        else r.status = rhht_pkg::StMissing;
      end
      rhht_pkg::ModeClear: begin
        for (int i = 0; i < Slots; i++) tbl_used[i] = 0;
        tbl_count = 0;
      end
      default: ;
    endcase
    r.stored_count = tbl_count[10:0];
    return r;
  endfunction

  // Hashes are derived from keys by a multiply with 32'h9E3779B1, with the
  // low four bits XORed with the low key bits; home slots span the table.
  function automatic logic [31:0] hash_of(logic [31:0] k);
    logic [31:0] h;
    h = k * 32'h9E3779B1;
    return {h[31:4], k[3:0] ^ h[3:0]};
  endfunction

  function automatic rhht_pkg::req_t make_word(logic [2:0] m, logic [31:0] k,
                                               logic [31:0] h, logic [31:0] v);
    rhht_pkg::req_t w;
    w.mode = m;
    w.key = k;
    w.key_hash = h;
    w.value_in = v;
    return w;
  endfunction

  task automatic queue_word(rhht_pkg::req_t w);
    pending_words.push_back(w);
    expected_words.push_back(table_response(w));
  endtask

  function automatic logic [31:0] pick_key();
    if (live_keys.size() > 0 && $urandom_range(0, 3) != 0)
      return live_keys[$urandom_range(0, live_keys.size() - 1)];
    return $urandom_range(0, 2047);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    int unsigned fill;
    logic [31:0] k;
    logic [31:0] h;
    logic [2:0] m;
    int unsigned r;
    rhht_pkg::req_t w;
    stimulus_done = 0;
    idle_off = 0;
    tbl_count = 0;
    for (int i = 0; i < Slots; i++) tbl_used[i] = 0;

    queue_word(make_word(rhht_pkg::ModeLookup, 32'h0, 32'h0, 32'h0));
    queue_word(make_word(rhht_pkg::ModeRemove, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0));
    queue_word(make_word(rhht_pkg::ModeAdd, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
    queue_word(make_word(rhht_pkg::ModeAdd, 32'h0, 32'h0, 32'h0));
    queue_word(make_word(rhht_pkg::ModeAdd, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h12345678));
    queue_word(make_word(rhht_pkg::ModeSet, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hA5A5A5A5));
    queue_word(make_word(rhht_pkg::ModeLookup, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0));
    queue_word(make_word(rhht_pkg::ModeAdd, 32'h5, 32'h3FF, 32'h5A5A5A5A));
    queue_word(make_word(rhht_pkg::ModeAdd, 32'h6, 32'h3FF, 32'h0F0F0F0F));
    queue_word(make_word(rhht_pkg::ModeAdd, 32'h5, 32'h7FF, 32'h1));
    queue_word(make_word(rhht_pkg::ModeSet, 32'h9, 32'h3FE, 32'h2));
    queue_word(make_word(rhht_pkg::ModeLookup, 32'h6, 32'h3FF, 32'h0));
    queue_word(make_word(rhht_pkg::ModeLookup, 32'h6, 32'h3FE, 32'h0));
    queue_word(make_word(rhht_pkg::ModeRemove, 32'h5, 32'h3FF, 32'h0));
    queue_word(make_word(rhht_pkg::ModeLookup, 32'h6, 32'h3FF, 32'h0));
    queue_word(make_word(rhht_pkg::ModeLookup, 32'h5, 32'h7FF, 32'h0));
    queue_word(make_word(3'd5, 32'h1, 32'h1, 32'h1));
    queue_word(make_word(3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
    queue_word(make_word(rhht_pkg::ModeClear, 32'h0, 32'h0, 32'h0));
    queue_word(make_word(rhht_pkg::ModeLookup, 32'h6, 32'h3FF, 32'h0));

    // The table is filled to the load limit so that new keys are refused.
    for (fill = 0; fill < 925; fill++) begin
      k = $urandom();
      queue_word(make_word(rhht_pkg::ModeAdd, k, hash_of(k), $urandom()));
    end
    queue_word(make_word(rhht_pkg::ModeSet, 32'h12345, hash_of(32'h12345), 32'h1));
    queue_word(make_word(rhht_pkg::ModeClear, 32'h0, 32'h0, 32'h0));

    for (int i = 0; i < 500; i++) begin
      if (i == 400) idle_off = 1;
      r = $urandom_range(0, 99);
      if (r < 1) begin
        m = rhht_pkg::ModeClear;
        live_keys.delete();
      end else if (r < 2) begin
        m = 3'($urandom_range(5, 7));
      end else if (r < 30) m = rhht_pkg::ModeAdd;
      else if (r < 50) m = rhht_pkg::ModeSet;
      else if (r < 75) m = rhht_pkg::ModeLookup;
      else m = rhht_pkg::ModeRemove;
      k = pick_key();
      h = hash_of(k);
      if ($urandom_range(0, 19) == 0) h = $urandom();
      w = make_word(m, k, h, $urandom());
      if ((m == rhht_pkg::ModeAdd || m == rhht_pkg::ModeSet) && live_keys.size() < 600)
        live_keys.push_back(k);
      queue_word(w);
    end
    stimulus_done = 1;
  end

  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned hold_cycles;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data <= '0;
      send_gap <= 0;
    end else begin
      if (req_if.valid && req_if.ready) pending_words.pop_front();
      if (!req_if.valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          req_if.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          if (!idle_off && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(1, 19);
            req_if.valid <= 1'b0;
          end else begin
            req_if.valid <= 1'b1;
            req_if.data <= pending_words[0];
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      recv_gap <= 0;
      hold_cycles <= 0;
      long_hold <= 0;
    end else begin
      if (!long_hold && cycle_count == 3000) begin
        long_hold <= 1;
        hold_cycles <= 400;
        rsp_if.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        rsp_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        rsp_if.ready <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 11) == 0) begin
        recv_gap <= $urandom_range(1, 19);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    rhht_pkg::rsp_t want;
    if (!rst_ni) begin
      mismatches <= 0;
    end else if (rsp_if.valid && rsp_if.ready) begin
      if (expected_words.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("Unexpected response word %h", rsp_if.data);
      end else begin
        want = expected_words.pop_front();
        if (rsp_if.data.status !== want.status || rsp_if.data.value_out !== want.value_out
            || rsp_if.data.stored_count !== want.stored_count) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("Mismatch: expected status %0d value %h count %0d, got %0d %h %0d",
                     want.status, want.value_out, want.stored_count, rsp_if.data.status,
                     rsp_if.data.value_out, rsp_if.data.stored_count);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!(stimulus_done && pending_words.size() == 0 && expected_words.size() == 0)
           && cycle_count < LimitCycles) begin
      @(posedge clk_i);
      cycle_count++;
    end
    if (cycle_count >= LimitCycles) begin
      $display("Testbench completed WITH ERRORS");
    end else begin
      repeat (2 * Slots) @(posedge clk_i);
      if (mismatches == 0 && expected_words.size() == 0) begin
        $display("Testbench completed without errors");
      end else begin
        $display("Testbench completed WITH ERRORS");
      end
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/rhht_pkg.sv
hw/rtl/rhht_if.sv
hw/rtl/rhht_datapath.sv
hw/rtl/rhht_ctrl.sv
hw/rtl/robin_hood_hash_table.sv
hw/rtl/rhht_checker.sv
bench/robin_hood_hash_table_tb.sv
